### hdl/s_shape_membership_top_macros.svh
// ----------------------------------------------------------------------------
// s-shape membership assertion macros
// clocked implication checks used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef S_SHAPE_MEMBERSHIP_TOP_MACROS_SVH
`define S_SHAPE_MEMBERSHIP_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define SHMF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
`define SHMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHMF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define SHMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/shmf_pkg.sv
// ----------------------------------------------------------------------------
// shmf_pkg
// types and constants of the s-shaped membership term
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shmf_pkg;

  localparam int DATA_W      = 32;
  localparam int HEIGHT_W    = 17;
  localparam int RATIO_BITS  = 24;
  localparam int LEVEL_QBITS = 32;
  localparam int ROOT_W      = 24;
  localparam int LEVEL_SHIFT = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [HEIGHT_W-1:0] DEG_ONE = 17'd65536;
  localparam logic [DATA_W-1:0]   POS_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0]   POS_MIN = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_EVAL   = 1'b0;
  localparam logic OP_INVERT = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] sample;
    logic [HEIGHT_W-1:0]      level;
  } req_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0]      degree;
    logic signed [DATA_W-1:0] position;
    logic                     height_error;
  } rsp_t;

endpackage

### hdl/shmf_delay.sv
// ----------------------------------------------------------------------------
// shmf_delay
// fixed-length shift line that keeps sideband data aligned with the datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shmf_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= data_i;
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk_i) begin
      tap_q[k] <= tap_q[k-1];
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

### hdl/shmf_div_pipe.sv
// ----------------------------------------------------------------------------
// shmf_div_pipe
// restoring divider, one quotient bit per register stage, dividend below divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shmf_div_pipe #(
  parameter int DIV_W  = 33,
  parameter int Q_BITS = 24
) (
  input  logic              clk_i,
  input  logic [DIV_W-1:0]  rem_i,
  input  logic [DIV_W-1:0]  div_i,
  output logic [Q_BITS-1:0] quo_o
);

  logic [DIV_W-1:0]  rem_q [Q_BITS];
  logic [DIV_W-1:0]  div_q [Q_BITS];
  logic [Q_BITS-1:0] quo_q [Q_BITS];

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    logic [DIV_W-1:0]  rem_in;
    logic [DIV_W-1:0]  div_in;
    logic [Q_BITS-1:0] quo_in;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign div_in = div_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      shifted = {rem_in, 1'b0};
      diff    = shifted - {1'b0, div_in};
      ge      = (shifted >= {1'b0, div_in});
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      div_q[k] <= div_in;
      quo_q[k] <= {quo_in[Q_BITS-2:0], ge};
    end
  end

  assign quo_o = quo_q[Q_BITS-1];

endmodule

### hdl/shmf_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// shmf_sqrt_pipe
// digit-by-digit integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shmf_sqrt_pipe #(
  parameter int ROOT_W = 24
) (
  input  logic                  clk_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W-1:0]     root_o
);

  logic [2*ROOT_W-1:0] rad_q  [ROOT_W-1];
  logic [ROOT_W+1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [2*ROOT_W-1:0] rad_in;
    logic [ROOT_W+1:0]   rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [ROOT_W+3:0]   cur;
    logic [ROOT_W+3:0]   trial;
    logic [ROOT_W+3:0]   diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      // bring down the next two radicand bits
      cur   = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
      root_q[k] <= {root_in[ROOT_W-2:0], ge};
    end

    if (k < ROOT_W - 1) begin : g_rad
      always_ff @(posedge clk_i) begin
        rad_q[k] <= {rad_in[2*ROOT_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

### hdl/s_shape_membership_top.sv
// ----------------------------------------------------------------------------
// s_shape_membership_top
// s-shaped fuzzy membership term: degree of a sample, or inverse of a level
// ----------------------------------------------------------------------------
//  channel   signals                         direction  timing
//  request   start_i, busy_o, req_i          in         taken when start_i & !busy_o
//  result    done_o, rsp_o                   out        one-cycle strobe, no stall
//  config    cfg_we_i, cfg_idx_i, cfg_data_i in         written when cfg_we_i
//
//  one request per clock; each result leaves after the stages listed below
//  stages: 1 prep stage, 32 level-divider stages, 24 root stages, 2 to finish
//  evaluations use a 24-stage ratio divider and are delayed to the same slot
//  busy_o stays low; reset clears the valid line and restores the config registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "s_shape_membership_top_macros.svh"

module s_shape_membership_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  shmf_pkg::req_t                  req_i,
  output logic                            done_o,
  output shmf_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_we_i,
  input  logic [shmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [shmf_pkg::DATA_W-1:0]     cfg_data_i
);

  localparam int DW     = shmf_pkg::DATA_W;
  localparam int HW     = shmf_pkg::HEIGHT_W;
  localparam int RB     = shmf_pkg::RATIO_BITS;
  localparam int RW     = shmf_pkg::ROOT_W;
  localparam int ST_SQ  = 1 + RB + 1;
  localparam int ST_DEG = ST_SQ + 1;
  localparam int ST_G   = 1 + shmf_pkg::LEVEL_QBITS + RW;
  localparam int ST_MUL = ST_G + 1;
  localparam int ST_OUT = ST_MUL + 1;
  localparam int INV_SB = 4 + DW;

  // configuration
  logic signed [DW-1:0] start_q, end_q;
  logic [HW-1:0]        height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      end_q    <= 32'sd65536;
      height_q <= shmf_pkg::DEG_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        shmf_pkg::REG_START:  start_q  <= cfg_data_i;
        shmf_pkg::REG_END:    end_q    <= cfg_data_i;
        shmf_pkg::REG_HEIGHT: height_q <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  logic [HW-1:0] h;
  assign h = (height_q > shmf_pkg::DEG_ONE) ? shmf_pkg::DEG_ONE : height_q;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  logic [ST_OUT:1] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ST_OUT-1:1], accept};
    end
  end

  // prep
  logic signed [DW:0]   x33, s33, e33, w33, dlo33, dhi33;
  logic signed [DW+1:0] x2, se_sum;
  logic                 le_s, ge_e, low_half;
  logic [HW-1:0]        y, u;
  logic                 lower;
  logic [DW:0]          m33;

  always_comb begin
    x33      = {req_i.sample[DW-1], req_i.sample};
    s33      = {start_q[DW-1], start_q};
    e33      = {end_q[DW-1], end_q};
    w33      = e33 - s33;
    dlo33    = x33 - s33;
    dhi33    = e33 - x33;
    le_s     = (req_i.sample <= start_q);
    ge_e     = (req_i.sample >= end_q);
    x2       = {x33, 1'b0};
    se_sum   = {s33[DW], s33} + {e33[DW], e33};
    low_half = (x2 <= se_sum);
    y        = (req_i.level > h) ? h : req_i.level;
    lower    = ({y, 1'b0} <= {1'b0, h});
    u        = lower ? y : (h - y);
    m33      = w33[DW] ? (-w33) : w33;
  end

  logic [DW:0]     p1_d_q, p1_w_q;
  logic [2:0]      p1_cls_q;
  logic [HW:0]     p1_u_q, p1_div_q;
  logic [INV_SB-1:0] p1_inv_q;

  always_ff @(posedge clk_i) begin
    p1_d_q   <= low_half ? dlo33 : dhi33;
    p1_w_q   <= w33;
    p1_cls_q <= {le_s, ge_e & ~le_s, low_half};
    p1_u_q   <= {1'b0, u};
    p1_div_q <= {h, 1'b0};
    p1_inv_q <= {req_i.operation, (h == '0), lower, w33[DW], m33[DW-1:0]};
  end

  // evaluation path
  logic [RB-1:0] q0;
  shmf_div_pipe #(.DIV_W(DW + 1), .Q_BITS(RB)) u_ratio_div (
    .clk_i (clk_i),
    .rem_i (p1_d_q),
    .div_i (p1_w_q),
    .quo_o (q0)
  );

  logic [2:0] cls;
  shmf_delay #(.WIDTH(3), .DEPTH(ST_SQ - 1)) u_cls_dly (
    .clk_i  (clk_i),
    .data_i (p1_cls_q),
    .data_o (cls)
  );

  logic [2*RB-1:0] qq;
  logic [RB-1:0]   sq_q;
  assign qq = q0 * q0;
  always_ff @(posedge clk_i) begin
    sq_q <= qq[2*RB-1:RB];
  end

  logic [RB:0]      sq2, mop;
  logic [HW+RB:0]   dprod;
  logic [HW-1:0]    deg_d, deg_q;
  always_comb begin
    sq2   = {sq_q, 1'b0};
    mop   = cls[0] ? sq2 : ((25'd1 << RB) - sq2);
    dprod = h * mop;
    if (cls[2]) begin
      deg_d = '0;
    end else if (cls[1]) begin
      deg_d = h;
    end else if (!cls[0] && (sq2 > (25'd1 << RB))) begin
      deg_d = '0;
    end else begin
      deg_d = dprod[HW+RB-1:RB];
    end
  end
  always_ff @(posedge clk_i) begin
    deg_q <= deg_d;
  end

  logic [HW-1:0] deg_mul;
  shmf_delay #(.WIDTH(HW), .DEPTH(ST_MUL - ST_DEG)) u_deg_dly (
    .clk_i  (clk_i),
    .data_i (deg_q),
    .data_o (deg_mul)
  );

  // inversion path
  logic [shmf_pkg::LEVEL_QBITS-1:0] f;
  shmf_div_pipe #(.DIV_W(HW + 1), .Q_BITS(shmf_pkg::LEVEL_QBITS)) u_level_div (
    .clk_i (clk_i),
    .rem_i (p1_u_q),
    .div_i (p1_div_q),
    .quo_o (f)
  );

  logic [RW-1:0] g;
  shmf_sqrt_pipe #(.ROOT_W(RW)) u_root (
    .clk_i  (clk_i),
    .rad_i  ({f, {shmf_pkg::LEVEL_SHIFT{1'b0}}}),
    .root_o (g)
  );

  logic [INV_SB-1:0] inv_sb;
  shmf_delay #(.WIDTH(INV_SB), .DEPTH(ST_G - 1)) u_inv_dly (
    .clk_i  (clk_i),
    .data_i (p1_inv_q),
    .data_o (inv_sb)
  );

  logic [DW-1:0]   hi_prod;
  logic [2*RB-1:0] lo_prod;
  logic [DW-1:0]   hi_q;
  logic [RB-1:0]   lo_q;
  logic [3:0]      flg_q;
  assign hi_prod = inv_sb[DW-1:RB] * g;
  assign lo_prod = inv_sb[RB-1:0] * g;
  always_ff @(posedge clk_i) begin
    hi_q  <= hi_prod;
    lo_q  <= lo_prod[2*RB-1:RB];
    flg_q <= inv_sb[INV_SB-1:DW];
  end

  // finish: flg_q = {operation, zero height, lower half, negative width}
  logic [DW:0]          mag;
  logic signed [DW+1:0] delta;
  logic signed [DW+2:0] pos35;
  logic [DW-1:0]        pos_sat;
  shmf_pkg::rsp_t       rsp_d, rsp_q;

  always_comb begin
    mag   = {1'b0, hi_q} + {{(DW + 1 - RB){1'b0}}, lo_q};
    delta = flg_q[0] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (flg_q[1]) begin
      pos35 = {{3{start_q[DW-1]}}, start_q} + {delta[DW+1], delta};
    end else begin
      pos35 = {{3{end_q[DW-1]}}, end_q} - {delta[DW+1], delta};
    end
    if (pos35[DW+2:DW-1] == '0 || pos35[DW+2:DW-1] == '1) begin
      pos_sat = pos35[DW-1:0];
    end else begin
      pos_sat = pos35[DW+2] ? shmf_pkg::POS_MIN : shmf_pkg::POS_MAX;
    end
    rsp_d = '0;
    if (flg_q[3] == shmf_pkg::OP_EVAL) begin
      rsp_d.degree = deg_mul;
    end else if (flg_q[2]) begin
      rsp_d.position     = start_q;
      rsp_d.height_error = 1'b1;
    end else begin
      rsp_d.position = pos_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = vld_q[ST_OUT];
  assign rsp_o  = rsp_q;

  `SHMF_ASSERT_IMPLY(a_deg_excl, clk_i, rst_ni, done_o && rsp_o.degree != '0,
    rsp_o.position == '0 && !rsp_o.height_error, "degree and position both set")
  `SHMF_ASSERT_IMPLY(a_err_start, clk_i, rst_ni, done_o && rsp_o.height_error,
    rsp_o.position == start_q && rsp_o.degree == '0, "height error without start")
  `SHMF_ASSERT_IMPLY(a_deg_range, clk_i, rst_ni, done_o,
    rsp_o.degree <= h, "degree above peak height")
  `SHMF_ASSERT_NEXT(a_accept_vld, clk_i, rst_ni, accept, vld_q[1], "request lost at entry")

endmodule
